// ===== rtl/gradient_noise_2d_defines.svh =====
// Assertion macros for the gradient noise block.
`ifndef GRADIENT_NOISE_2D_DEFINES_SVH
`define GRADIENT_NOISE_2D_DEFINES_SVH

`ifndef SYNTHESIS

// Condition must hold at every clock edge out of reset.
`define GN2D_CHECK(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("gn2d check failed");

// Antecedent true implies consequent in the same cycle.
`define GN2D_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("gn2d implication failed");

`else

`define GN2D_CHECK(lbl, cond)
`define GN2D_IMPLY(lbl, ante, cons)

`endif

`endif

// ===== rtl/gn2d_pkg.sv =====
// Shared types and constants for the gradient noise block.
package gn2d_pkg;

   localparam int COORD_W = 32;
   localparam int OUT_W   = 18;

   // Corner hash constants
   localparam logic [31:0] HASH_K1 = 32'd374761393;
   localparam logic [31:0] HASH_K2 = 32'd668265263;
   localparam logic [31:0] HASH_K3 = 32'd1274126177;
   localparam int          HASH_SH1 = 13;
   localparam int          HASH_SH2 = 16;

   // Smootherstep Horner coefficients
   localparam int FADE_C6  = 6;
   localparam int FADE_C15 = 15;
   localparam int FADE_C10 = 10;

   // Gradient picked by the low hash bits
   typedef enum logic [1:0] {
      GRAD_POS_X = 2'd0,
      GRAD_NEG_X = 2'd1,
      GRAD_POS_Z = 2'd2,
      GRAD_NEG_Z = 2'd3
   } grad_type;

endpackage

// ===== rtl/gn2d_hash.sv =====
// Three-stage corner hash: gradient choice for the four cell corners.
module gn2d_hash
   import gn2d_pkg::*;
(
   input  logic        clock,
   input  logic [31:0] cell_x,
   input  logic [31:0] cell_z,
   output grad_type    grad_sel [4]
);

   logic [31:0] ax_ff;
   logic [31:0] az_ff;
   logic [31:0] mix_ff [4];
   logic [31:0] mul_ff [4];

   // stage 1: per-axis products, shared by all four corners
   always_ff @(posedge clock) begin
      ax_ff <= cell_x * HASH_K1;
      az_ff <= cell_z * HASH_K2;
   end

   for (genvar c = 0; c < 4; c++) begin : g_corner
      // (x+1)*K1 = x*K1 + K1, likewise for z
      localparam logic [31:0] OFS = ((c % 2) != 0 ? HASH_K1 : 32'd0) +
                                    ((c / 2) != 0 ? HASH_K2 : 32'd0);
      logic [31:0] h_sum;
      logic [31:0] h_asr;

      always_comb begin
         h_sum = ax_ff + az_ff + OFS;
         h_asr = 32'($signed(h_sum) >>> HASH_SH1);
      end

      // stage 2: xor-shift, stage 3: final multiply
      always_ff @(posedge clock) begin
         mix_ff[c] <= h_sum ^ h_asr;
         mul_ff[c] <= mix_ff[c] * HASH_K3;
      end

      // low two bits of h ^ (h >>> 16)
      assign grad_sel[c] = grad_type'(mul_ff[c][1:0] ^ mul_ff[c][HASH_SH2+1:HASH_SH2]);
   end

endmodule

// ===== rtl/gn2d_fade.sv =====
// Five-stage smootherstep pipeline, 6t^5 - 15t^4 + 10t^3 by Horner's rule.
module gn2d_fade
   import gn2d_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic [FRAC_BITS-1:0]        frac,
   output logic signed [FRAC_BITS+1:0] weight
);

   localparam int AW = FRAC_BITS + 6;           // Horner terms, within (-16, 16)
   localparam int PW = FRAC_BITS + 1 + AW;      // t times a Horner term
   localparam logic signed [AW-1:0] C15 = AW'(FADE_C15 * (1 << FRAC_BITS));
   localparam logic signed [AW-1:0] C10 = AW'(FADE_C10 * (1 << FRAC_BITS));

   logic [FRAC_BITS-1:0]  t_ff [4];
   logic signed [AW-1:0]  a_ff;
   logic signed [PW-1:0]  pa_ff;
   logic signed [PW-1:0]  pb_ff;
   logic signed [PW-1:0]  pc_ff;
   logic signed [PW-1:0]  pd_ff;

   logic signed [AW-1:0]        t_ext;
   logic signed [AW-1:0]        a_in;
   logic signed [AW-1:0]        b_term;
   logic signed [FRAC_BITS:0]   ts1;
   logic signed [FRAC_BITS:0]   ts2;
   logic signed [FRAC_BITS:0]   ts3;
   logic signed [FRAC_BITS:0]   ts4;

   always_comb begin
      t_ext  = $signed(AW'(frac));
      a_in   = t_ext * AW'(FADE_C6) - C15;
      ts1    = $signed({1'b0, t_ff[0]});
      ts2    = $signed({1'b0, t_ff[1]});
      ts3    = $signed({1'b0, t_ff[2]});
      ts4    = $signed({1'b0, t_ff[3]});
      // upper bits of a product are the floor of product / 2^F
      b_term = $signed(pa_ff[FRAC_BITS +: AW]) + C10;
   end

   always_ff @(posedge clock) begin
      t_ff[0] <= frac;
      t_ff[1] <= t_ff[0];
      t_ff[2] <= t_ff[1];
      t_ff[3] <= t_ff[2];
      a_ff    <= a_in;
      pa_ff   <= ts1 * a_ff;
      pb_ff   <= ts2 * b_term;
      pc_ff   <= ts3 * $signed(pb_ff[FRAC_BITS +: AW]);
      pd_ff   <= ts4 * $signed(pc_ff[FRAC_BITS +: AW]);
   end

   // result lies in [0, 1]
   assign weight = $signed(pd_ff[FRAC_BITS +: FRAC_BITS+2]);

endmodule

// ===== rtl/gradient_noise_2d.sv =====
// Top level of the 2D gradient noise pipeline.
// Usage
//   Input: a sample point (req_point_x, req_point_z), signed Q16.16 by default,
//   is transferred at a rising edge where start is high and busy is low.
//   busy is high only while reset is asserted; otherwise a point may be
//   transferred on every cycle.
//   Output: rsp_noise_value (signed Q1.16, saturated to [-1, 1]) is shown for
//   exactly one cycle with rsp_strobe high; the transfer completes at the edge
//   that ends that cycle. There is no back-pressure on this side.
//   Throughput: one sample per cycle outside reset, set by the fully pipelined
//   datapath (two fade pipelines, a three-stage hash, four blend stages).
//   Results leave in the order the points came in.
//   Reset (synchronous): clears the valid chain, so samples still in flight
//   are dropped and produce no strobe. Payload registers are not reset.
// Pipeline
//   S1-S3  corner hash in gn2d_hash; fraction bits follow alongside
//   S1-S5  smootherstep weights u, v in two gn2d_fade instances
//   S4     corner dot products, S5 aligns them with u and v
//   S6-S7  x blends (bottom, top), S8-S9 z blend and saturation
`include "gradient_noise_2d_defines.svh"

module gradient_noise_2d
   import gn2d_pkg::*;
#(
   parameter int FRAC_BITS = 16,
   parameter int INT_BITS  = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic signed [COORD_W-1:0] req_point_x,
   input  logic signed [COORD_W-1:0] req_point_z,
   output logic                      rsp_strobe,
   output logic signed [OUT_W-1:0]   rsp_noise_value
);

   localparam int LAT = 9;
   localparam int CW  = (INT_BITS + FRAC_BITS > COORD_W) ? COORD_W : INT_BITS + FRAC_BITS;
   localparam int SH  = COORD_W - CW;
   localparam int DW  = FRAC_BITS + 2;          // dots and weights, [-1, 1]
   localparam int EW  = FRAC_BITS + 3;          // first differences, bottom/top
   localparam int PBW = EW + DW;                // x blend product
   localparam int FW  = PBW - FRAC_BITS;        // floored x blend product
   localparam int GW  = FRAC_BITS + 4;          // top - bottom
   localparam int PRW = GW + DW;                // z blend product
   localparam int RW  = PRW - FRAC_BITS;        // final sum
   localparam logic signed [DW-1:0] ONE_D = DW'(1 << FRAC_BITS);
   localparam logic signed [RW-1:0] ONE_R = RW'(1 << FRAC_BITS);

   // ---------------- input transfer and coordinate decode ----------------
   logic                      accept;
   logic [COORD_W-1:0]        x_shl;
   logic [COORD_W-1:0]        z_shl;
   logic signed [COORD_W-1:0] px;
   logic signed [COORD_W-1:0] pz;
   logic [COORD_W-1:0]        cell_x;
   logic [COORD_W-1:0]        cell_z;

   assign busy   = reset;
   assign accept = start & ~busy;

   always_comb begin
      // keep the low CW bits, read as signed
      x_shl  = req_point_x << SH;
      z_shl  = req_point_z << SH;
      px     = $signed(x_shl) >>> SH;
      pz     = $signed(z_shl) >>> SH;
      cell_x = COORD_W'(px >>> FRAC_BITS);
      cell_z = COORD_W'(pz >>> FRAC_BITS);
   end

   // valid chain, one bit per stage
   logic [LAT-1:0] vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAT-2:0], accept};
      end
   end

   // ---------------- hash and fade units ----------------
   grad_type                grad_sel [4];
   logic signed [DW-1:0]    u_w;
   logic signed [DW-1:0]    v_w;

   gn2d_hash u_hash (
      .clock    (clock),
      .cell_x   (cell_x),
      .cell_z   (cell_z),
      .grad_sel (grad_sel)
   );

   gn2d_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_x (
      .clock  (clock),
      .frac   (px[FRAC_BITS-1:0]),
      .weight (u_w)
   );

   gn2d_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_z (
      .clock  (clock),
      .frac   (pz[FRAC_BITS-1:0]),
      .weight (v_w)
   );

   // ---------------- S1-S3: fractions follow the hash ----------------
   logic [FRAC_BITS-1:0] fx_ff [3];
   logic [FRAC_BITS-1:0] fz_ff [3];

   always_ff @(posedge clock) begin
      fx_ff[0] <= px[FRAC_BITS-1:0];
      fz_ff[0] <= pz[FRAC_BITS-1:0];
      fx_ff[1] <= fx_ff[0];
      fz_ff[1] <= fz_ff[0];
      fx_ff[2] <= fx_ff[1];
      fz_ff[2] <= fz_ff[1];
   end

   // ---------------- S4: corner dot products ----------------
   // corner index: bit 0 selects x+1, bit 1 selects z+1
   logic signed [DW-1:0] ox0, ox1, oz0, oz1;
   logic signed [DW-1:0] dot_in [4];
   logic signed [DW-1:0] dot_s4_ff [4];
   logic signed [DW-1:0] dot_s5_ff [4];

   always_comb begin
      ox0 = $signed({2'b00, fx_ff[2]});
      oz0 = $signed({2'b00, fz_ff[2]});
      ox1 = ox0 - ONE_D;
      oz1 = oz0 - ONE_D;
   end

   for (genvar c = 0; c < 4; c++) begin : g_dot
      logic signed [DW-1:0] ox;
      logic signed [DW-1:0] oz;

      always_comb begin
         ox = ((c % 2) != 0) ? ox1 : ox0;
         oz = ((c / 2) != 0) ? oz1 : oz0;
         case (grad_sel[c])
            GRAD_POS_X: dot_in[c] = ox;
            GRAD_NEG_X: dot_in[c] = -ox;
            GRAD_POS_Z: dot_in[c] = oz;
            GRAD_NEG_Z: dot_in[c] = -oz;
            default:    dot_in[c] = ox;
         endcase
      end

      always_ff @(posedge clock) begin
         dot_s4_ff[c] <= dot_in[c];
         dot_s5_ff[c] <= dot_s4_ff[c];
      end
   end

   // ---------------- S6: x blend products ----------------
   logic signed [PBW-1:0] pbot_ff;
   logic signed [PBW-1:0] ptop_ff;
   logic signed [DW-1:0]  d00_s6_ff;
   logic signed [DW-1:0]  d01_s6_ff;
   logic signed [DW-1:0]  v_s6_ff;
   logic signed [EW-1:0]  dx_bot;
   logic signed [EW-1:0]  dx_top;

   always_comb begin
      dx_bot = EW'(dot_s5_ff[1]) - EW'(dot_s5_ff[0]);
      dx_top = EW'(dot_s5_ff[3]) - EW'(dot_s5_ff[2]);
   end

   always_ff @(posedge clock) begin
      pbot_ff   <= dx_bot * u_w;
      ptop_ff   <= dx_top * u_w;
      d00_s6_ff <= dot_s5_ff[0];
      d01_s6_ff <= dot_s5_ff[2];
      v_s6_ff   <= v_w;
   end

   // ---------------- S7: bottom and top ----------------
   logic signed [EW-1:0] bot_ff;
   logic signed [EW-1:0] top_ff;
   logic signed [DW-1:0] v_s7_ff;
   logic signed [FW-1:0] bot_sum;
   logic signed [FW-1:0] top_sum;

   always_comb begin
      bot_sum = FW'(d00_s6_ff) + $signed(pbot_ff[PBW-1:FRAC_BITS]);
      top_sum = FW'(d01_s6_ff) + $signed(ptop_ff[PBW-1:FRAC_BITS]);
   end

   always_ff @(posedge clock) begin
      bot_ff  <= EW'(bot_sum);
      top_ff  <= EW'(top_sum);
      v_s7_ff <= v_s6_ff;
   end

   // ---------------- S8: z blend product ----------------
   logic signed [PRW-1:0] pr_ff;
   logic signed [EW-1:0]  bot_s8_ff;
   logic signed [GW-1:0]  dz_diff;

   assign dz_diff = GW'(top_ff) - GW'(bot_ff);

   always_ff @(posedge clock) begin
      pr_ff     <= dz_diff * v_s7_ff;
      bot_s8_ff <= bot_ff;
   end

   // ---------------- S9: final sum, saturate, output register ----------------
   logic signed [RW-1:0]    r_sum;
   logic signed [RW-1:0]    r_sat;
   logic signed [OUT_W-1:0] noise_ff;

   always_comb begin
      r_sum = RW'(bot_s8_ff) + $signed(pr_ff[PRW-1:FRAC_BITS]);
      if (r_sum > ONE_R) begin
         r_sat = ONE_R;
      end else if (r_sum < -ONE_R) begin
         r_sat = -ONE_R;
      end else begin
         r_sat = r_sum;
      end
   end

   always_ff @(posedge clock) begin
      noise_ff <= OUT_W'(r_sat);
   end

   assign rsp_strobe      = vld_ff[LAT-1];
   assign rsp_noise_value = noise_ff;

   // ---------------- checks ----------------
   // point on a lattice node: both fractions zero
   logic lattice_pt;

   assign lattice_pt = (req_point_x[FRAC_BITS-1:0] == '0) && (req_point_z[FRAC_BITS-1:0] == '0);

   `GN2D_CHECK(a_latency, rsp_strobe == $past(accept, LAT))
   `GN2D_IMPLY(a_weight_range, vld_ff[4], u_w >= 0 && u_w <= ONE_D && v_w >= 0 && v_w <= ONE_D)
   `GN2D_IMPLY(a_dot_range, vld_ff[3], dot_s4_ff[0] >= -ONE_D && dot_s4_ff[0] <= ONE_D)
   `GN2D_IMPLY(a_lattice_zero, rsp_strobe && $past(lattice_pt, LAT), rsp_noise_value == '0)

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the gradient_noise_2d pipeline.
`timescale 1ns / 100ps

module testbench
   import gn2d_pkg::*;
();

   localparam int      FRAC          = 16;
   localparam longint  ONE_FX        = longint'(1) << FRAC;
   localparam int      BURST_MAX     = 48;
   localparam int      GAP_MAX       = 12;
   localparam int      RANDOM_POINTS = 1650;
   // Idle cycles at the end, a comfortable margin over the pipeline latency.
   localparam int      TAIL_CYCLES   = 30;
   // Watchdog bound on cycles with no transfer, well above any quiet spell in a correct run.
   localparam int      WATCHDOG_MAX  = 400;
   localparam int      REPORT_MAX    = 40;

   // One point in flight and the noise value it should produce.
   typedef struct {
      logic signed [COORD_W-1:0] px;
      logic signed [COORD_W-1:0] pz;
      logic signed [OUT_W-1:0]   noise;
   } noise_expectation_type;

   // Scoreboard: predicts the noise for each input transfer and matches
   // results against the oldest prediction still waiting.
   class noise_scoreboard_type;
      noise_expectation_type pending_noise[$];
      int                    errors;

      function new();
         errors = 0;
      endfunction

      // Arithmetic shift right of a 32-bit word (copies the sign bit).
      function bit [31:0] shift_signed(bit [31:0] w, int amount);
         bit signed [31:0] ws;
         ws = w;
         ws = ws >>> amount;
         return ws;
      endfunction

      function bit [31:0] corner_hash(bit [31:0] cx, bit [31:0] cz);
         bit [31:0] h;
         h = cx * HASH_K1 + cz * HASH_K2;
         h = (h ^ shift_signed(h, HASH_SH1)) * HASH_K3;
         return h ^ shift_signed(h, HASH_SH2);
      endfunction

      function longint corner_dot(bit [31:0] cx, bit [31:0] cz, longint ox, longint oz);
         grad_type g;
         g = grad_type'(corner_hash(cx, cz) & 32'd3);
         case (g)
            GRAD_POS_X: return ox;
            GRAD_NEG_X: return -ox;
            GRAD_POS_Z: return oz;
            default:    return -oz;
         endcase
      endfunction

      // Smootherstep by Horner's rule; >>> on longint floors.
      function longint fade(longint t);
         longint a, b, c, d;
         a = FADE_C6 * t - FADE_C15 * ONE_FX;
         b = ((t * a) >>> FRAC) + FADE_C10 * ONE_FX;
         c = (t * b) >>> FRAC;
         d = (t * c) >>> FRAC;
         return (t * d) >>> FRAC;
      endfunction

      function longint blend(longint p, longint q, longint w);
         return p + (((q - p) * w) >>> FRAC);
      endfunction

      function logic signed [OUT_W-1:0] noise_at(logic signed [COORD_W-1:0] px_in,
                                                 logic signed [COORD_W-1:0] pz_in);
         longint    px, pz, fx, fz, u, v, d00, d10, d01, d11, bottom, top, r;
         bit [31:0] x0, z0, x1, z1;
         px = px_in;
         pz = pz_in;
         fx = px & (ONE_FX - 1);
         fz = pz & (ONE_FX - 1);
         x0 = 32'(px >>> FRAC);
         z0 = 32'(pz >>> FRAC);
         // far corner index wraps at 32 bits
         x1 = x0 + 32'd1;
         z1 = z0 + 32'd1;
         d00 = corner_dot(x0, z0, fx, fz);
         d10 = corner_dot(x1, z0, fx - ONE_FX, fz);
         d01 = corner_dot(x0, z1, fx, fz - ONE_FX);
         d11 = corner_dot(x1, z1, fx - ONE_FX, fz - ONE_FX);
         u = fade(fx);
         v = fade(fz);
         bottom = blend(d00, d10, u);
         top    = blend(d01, d11, u);
         r      = blend(bottom, top, v);
         if (r > ONE_FX) r = ONE_FX;
         if (r < -ONE_FX) r = -ONE_FX;
         return OUT_W'(r);
      endfunction

      function int outstanding();
         return pending_noise.size();
      endfunction

      function void note_point(logic signed [COORD_W-1:0] px, logic signed [COORD_W-1:0] pz);
         noise_expectation_type e;
         e.px    = px;
         e.pz    = pz;
         e.noise = noise_at(px, pz);
         pending_noise.push_back(e);
      endfunction

      task report(string what);
         if (errors < REPORT_MAX)
            $display("mismatch @%0t: %s", $realtime, what);
         errors++;
      endtask

      task check_noise(logic signed [OUT_W-1:0] got);
         noise_expectation_type e;
         if (pending_noise.size() == 0) begin
            report($sformatf("noise %0d with no point outstanding", got));
         end else begin
            e = pending_noise.pop_front();
            if (got !== e.noise)
               report($sformatf("point (%h, %h): noise %0d, expected %0d",
                                e.px, e.pz, got, e.noise));
         end
      endtask
   endclass

   logic                      clock;
   logic                      reset       = 1'b1;
   logic                      start       = 1'b0;
   logic                      busy;
   logic signed [COORD_W-1:0] req_point_x = '0;
   logic signed [COORD_W-1:0] req_point_z = '0;
   logic                      rsp_strobe;
   logic signed [OUT_W-1:0]   rsp_noise_value;

   noise_scoreboard_type sb = new();
   int                   quiet_cycles = 0;

   gradient_noise_2d u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_point_x     (req_point_x),
      .req_point_z     (req_point_z),
      .rsp_strobe      (rsp_strobe),
      .rsp_noise_value (rsp_noise_value)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Monitor: everything is sampled at the rising edge, where both transfers
   // complete. The watchdog counts cycles with no transfer on either side.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe)
            sb.check_noise(rsp_noise_value);
         if (start && !busy)
            sb.note_point(req_point_x, req_point_z);
         if (rsp_strobe || (start && !busy)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_MAX);
            $display("FAIL gradient_noise_2d");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Present one point from the falling edge; hold it until the transfer.
   task send_point(logic signed [COORD_W-1:0] px, logic signed [COORD_W-1:0] pz);
      @(negedge clock);
      start       <= 1'b1;
      req_point_x <= px;
      req_point_z <= pz;
      @(posedge clock);
      while (busy)
         @(posedge clock);
   endtask

   // Drop start for a number of cycles; junk on the fields must be ignored.
   task pause_sender(int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         start       <= 1'b0;
         req_point_x <= $urandom;
         req_point_z <= $urandom;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Hold off until every predicted noise value has come back.
   task drain_results();
      pause_sender(1);
      while (sb.outstanding() != 0)
         @(posedge clock);
   endtask

   // Random coordinate; the mix leans towards cell edges and index wrap.
   function logic signed [COORD_W-1:0] pick_coord();
      logic [15:0] cell_idx;
      logic [15:0] frac;
      case ($urandom_range(0, 9))
         0, 1, 2: return $urandom;
         3, 4: begin
            cell_idx = 16'($signed($urandom_range(0, 16)) - 8);
            frac     = 16'($urandom);
         end
         5, 6: begin
            cell_idx = 16'($urandom);
            case ($urandom_range(0, 4))
               0:       frac = 16'h0000;
               1:       frac = 16'h0001;
               2:       frac = 16'hFFFF;
               3:       frac = 16'h8000;
               default: frac = 16'h7FFF;
            endcase
         end
         default: begin
            case ($urandom_range(0, 3))
               0:       cell_idx = 16'h7FFF;
               1:       cell_idx = 16'h8000;
               2:       cell_idx = 16'hFFFF;
               default: cell_idx = 16'h0000;
            endcase
            frac = 16'($urandom);
         end
      endcase
      return {cell_idx, frac};
   endfunction

   initial begin
      int sent;
      int burst;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: field extremes, cell corners and fractions at their limits,
      // the -1 cell whose far corner wraps to zero, and the largest cell.
      send_point(32'sh0000_0000, 32'sh0000_0000);
      send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      send_point(32'sh8000_0000, 32'sh8000_0000);
      send_point(32'sh7FFF_FFFF, 32'sh8000_0000);
      send_point(32'sh8000_0000, 32'sh7FFF_FFFF);
      send_point(32'shFFFF_FFFF, 32'shFFFF_FFFF);
      send_point(32'shFFFF_0000, 32'sh0000_FFFF);
      send_point(32'sh0000_8000, 32'sh0000_8000);
      send_point(32'sh0000_0001, 32'shFFFF_8000);
      send_point(32'sh0001_0000, 32'sh0001_0000);
      send_point(32'sh7FFF_0000, 32'sh7FFF_8000);
      send_point(32'sh8000_FFFF, 32'sh0000_4000);
      send_point(32'sh5555_5555, 32'shAAAA_AAAA);
      send_point(32'shAAAA_AAAA, 32'sh5555_5555);
      pause_sender(3);
      send_point(32'sh0002_C000, 32'shFFFD_3000);
      send_point(32'sh1234_5678, 32'shFEDC_BA98);
      // a run of neighbouring cells
      for (int i = 0; i < 8; i++)
         send_point(32'(i) << 16 | 32'h0000_6000, 32'(i) << 15 | 32'h0000_A000);
      drain_results();

      // Random: bursts of back-to-back transfers, most separated by random gaps.
      sent = 0;
      while (sent < RANDOM_POINTS) begin
         burst = $urandom_range(1, BURST_MAX);
         for (int i = 0; i < burst && sent < RANDOM_POINTS; i++) begin
            send_point(pick_coord(), pick_coord());
            sent++;
         end
         // about a quarter of bursts run straight into the next one
         if ($urandom_range(0, 3) != 0)
            pause_sender($urandom_range(1, GAP_MAX));
         if (sent >= RANDOM_POINTS / 2 && sent - burst < RANDOM_POINTS / 2)
            drain_results();
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0)
         $display("PASS gradient_noise_2d");
      else
         $display("FAIL gradient_noise_2d");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/gn2d_pkg.sv
rtl/gn2d_hash.sv
rtl/gn2d_fade.sv
rtl/gradient_noise_2d.sv
tb/testbench.sv
